/* rtl/core/hevi_pkg.sv */
// ----------------------------------------------------------------------------
// hevi_pkg
// Shared types for the evolvent index-to-point block: controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hevi_pkg;

  // configuration register indexes
  localparam logic [3:0] CfgDimension = 4'd0;
  localparam logic [3:0] CfgTightness = 4'd1;

  // reset values of the configuration registers
  localparam logic [3:0] DimensionReset = 4'd2;
  localparam logic [4:0] TightnessReset = 5'd10;

  typedef enum logic [1:0] {
    StIdle,
    StLevel,
    StEmit
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // take a new request
    logic step;     // run one subdivision level
    logic advance;  // present one axis and move to the next
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;        // no level walk for the request being started
    logic last_level;  // current level is the final one
    logic last_axis;   // current axis is the final one
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/hevi_ctrl.sv */
// ----------------------------------------------------------------------------
// hevi_ctrl
// Sequencer: an idle state, a level state held for each subdivision level, and an emit state held for each axis.
// ----------------------------------------------------------------------------
`default_nettype none

module hevi_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire hevi_pkg::status_t status_i,
  output hevi_pkg::cmd_t        cmd_o
);

  hevi_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hevi_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hevi_pkg::StIdle: begin
        if (start) begin
          state_d = status_i.skip ? hevi_pkg::StEmit : hevi_pkg::StLevel;
        end
      end
      hevi_pkg::StLevel: begin
        if (status_i.last_level) state_d = hevi_pkg::StEmit;
      end
      hevi_pkg::StEmit: begin
        if (status_i.last_axis) state_d = hevi_pkg::StIdle;
      end
      default: state_d = hevi_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    unique case (state_q)
      hevi_pkg::StIdle: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      hevi_pkg::StLevel: cmd_o.step = 1'b1;
      hevi_pkg::StEmit:  cmd_o.advance = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/hevi_datapath.sv */
// ----------------------------------------------------------------------------
// hevi_datapath
// Configuration registers, digit shifter, cell shape logic, per-axis
// orientation and coordinate lanes, and the output selection.
// ----------------------------------------------------------------------------
`default_nettype none

module hevi_datapath #(
  parameter int MAX_AXES      = 10,
  parameter int MAX_LEVELS    = 20,
  parameter int POSITION_BITS = 60
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic [60:0]        position_i,
  input  wire hevi_pkg::cmd_t     cmd_i,
  output hevi_pkg::status_t       status_o,
  output logic signed [61:0]      coordinate_o,
  output logic [3:0]              axis_o,
  output logic                    last_o
);

  localparam int AW  = $clog2(MAX_AXES);
  localparam int NW  = $clog2(MAX_AXES + 1);
  localparam int LW  = $clog2(MAX_LEVELS + 1);
  localparam int P   = POSITION_BITS;

  // configuration registers
  logic [3:0] dim_q;
  logic [4:0] tight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= hevi_pkg::DimensionReset;
      tight_q <= hevi_pkg::TightnessReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hevi_pkg::CfgDimension: dim_q   <= cfg_data_i[3:0];
        hevi_pkg::CfgTightness: tight_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // effective dimension and level count
  logic [NW-1:0] n_eff;
  logic [LW-1:0] lv_eff;
  always_comb begin
    if (dim_q == 4'd0) n_eff = NW'(1);
    else if (32'(dim_q) > MAX_AXES) n_eff = NW'(MAX_AXES);
    else n_eff = NW'(dim_q);
    if (32'(tight_q) > MAX_LEVELS) lv_eff = LW'(MAX_LEVELS);
    else lv_eff = LW'(tight_q);
  end

  // saturated position
  logic        pos_full;
  logic [61:0] xs_wide;
  logic [61:0] dim1_coord;
  assign pos_full   = |position_i[60:P];
  assign xs_wide    = pos_full ? (62'(1) << P) : 62'(position_i[P-1:0]);
  assign dim1_coord = (xs_wide << (61 - P)) - (62'(1) << 60);

  // request state
  logic [NW-1:0]   n_q;
  logic [LW-1:0]   lvls_q, lev_q;
  logic            full_q;
  logic [P-1:0]    sr_q;
  logic [AW-1:0]   entry_q, axis_q;
  logic [MAX_AXES-1:0] on_q;
  logic signed [61:0]  coord_q [MAX_AXES];

  // digit of the current level
  logic [MAX_AXES-1:0] mask, dig, e, b;
  logic [P-1:0]        sr_sh;
  always_comb begin
    mask  = MAX_AXES'((1 << n_q) - 1);
    sr_sh = sr_q >> (P - 32'(n_q));
    dig   = full_q ? mask : (sr_sh[MAX_AXES-1:0] & mask);
    e     = dig << (MAX_AXES - 32'(n_q));
    for (int a = 0; a < MAX_AXES; a++) begin
      b[a] = e[MAX_AXES-1-a];
    end
  end

  // cell shape: direction and twist as sign bits (1 = negative), and the exit axis
  logic [MAX_AXES-1:0] dn, tn, dn2, tn2;
  logic [AW-1:0]       ex, ex2, nm1;
  always_comb begin
    nm1 = AW'(n_q - NW'(1));
    dn  = '0;
    dn[0] = ~b[0];
    for (int a = 1; a < MAX_AXES; a++) begin
      dn[a] = ~(b[a] ^ b[a-1]);
    end
    ex = nm1;
    for (int a = 0; a < MAX_AXES - 1; a++) begin
      if (a < 32'(n_q) - 1 && b[a] != b[a+1]) ex = AW'(a);
    end
    tn = dn;
    if (dig == '0) begin
      ex = nm1;
      dn = '1;
      tn = '1;
    end else if (dig == mask) begin
      ex     = nm1;
      dn     = '1;
      dn[0]  = 1'b0;
      tn     = '1;
      tn[0]  = 1'b0;
      tn[nm1] = 1'b0;
    end else begin
      tn[ex]  = tn[ex] ^ b[ex];
      tn[nm1] = ~tn[nm1];
    end
    // swap axis 0 with the entry axis
    dn2 = dn;
    tn2 = tn;
    dn2[0] = dn[entry_q];
    dn2[entry_q] = dn[0];
    tn2[0] = tn[entry_q];
    tn2[entry_q] = tn[0];
    if (ex == '0) ex2 = entry_q;
    else if (ex == entry_q) ex2 = '0;
    else ex2 = ex;
  end

  // step size of the current level
  logic [61:0] step;
  assign step = (62'(1) << 59) >> lev_q;

  // request registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lev_q  <= '0;
      axis_q <= '0;
    end else if (cmd_i.load) begin
      lev_q  <= '0;
      axis_q <= '0;
    end else begin
      if (cmd_i.step) lev_q <= lev_q + LW'(1);
      if (cmd_i.advance) axis_q <= axis_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= n_eff;
      lvls_q  <= lv_eff;
      full_q  <= pos_full;
      sr_q    <= position_i[P-1:0];
      entry_q <= '0;
      on_q    <= '0;
      // dimension one takes the plain offset on axis 0
      for (int a = 0; a < MAX_AXES; a++) begin
        if (a == 0 && n_eff == NW'(1)) coord_q[a] <= dim1_coord;
        else coord_q[a] <= '0;
      end
    end else if (cmd_i.step) begin
      sr_q    <= sr_q << n_q;
      entry_q <= ex2;
      for (int a = 0; a < MAX_AXES; a++) begin
        on_q[a] <= ~(tn2[a] ^ on_q[a]);
        if (dn2[a] ^ on_q[a]) coord_q[a] <= coord_q[a] - $signed(step);
        else coord_q[a] <= coord_q[a] + $signed(step);
      end
    end
  end

  // status and result
  assign status_o.skip       = (n_eff == NW'(1)) || (lv_eff == '0);
  assign status_o.last_level = (lev_q == lvls_q - LW'(1));
  assign status_o.last_axis  = (axis_q == AW'(n_q - NW'(1)));

  assign coordinate_o = coord_q[axis_q];
  assign axis_o       = 4'(axis_q);
  assign last_o       = status_o.last_axis;

endmodule

`default_nettype wire

/* rtl/core/hilbert_evolvent_index_to_point_top.sv */
// ----------------------------------------------------------------------------
// hilbert_evolvent_index_to_point_top
// Maps a curve position to a point of the centred cube along a Hilbert-type
// evolvent; one coordinate per axis is emitted with a one-cycle strobe.
// ----------------------------------------------------------------------------
// sequence: a request is taken when start is high while idle, then one level step per
// subdivision level (tightness, at most MAX_LEVELS; none for dimension one), then one
// result per axis (n = dimension); no new request is taken until the last axis is out
// busy is high from the cycle after start until the last axis is presented
// reset: dimension 2, tightness 10, sequencer idle; the receiver cannot stall
`default_nettype none

module hilbert_evolvent_index_to_point_top #(
  parameter int MAX_AXES      = 10,
  parameter int MAX_LEVELS    = 20,
  parameter int POSITION_BITS = 60
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [60:0]  position_i,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [3:0]   cfg_index_i,
  input  wire logic [7:0]   cfg_data_i,
  output logic              result_valid_o,
  output logic signed [61:0] coordinate_o,
  output logic [3:0]        axis_o,
  output logic              last_o
);

  hevi_pkg::cmd_t    cmd;
  hevi_pkg::status_t status;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  hevi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // datapath
  hevi_datapath #(
    .MAX_AXES      (MAX_AXES),
    .MAX_LEVELS    (MAX_LEVELS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .position_i   (position_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .coordinate_o (coordinate_o),
    .axis_o       (axis_o),
    .last_o       (last_o)
  );

  assign result_valid_o = cmd.advance;

endmodule

`default_nettype wire

/* test/hilbert_evolvent_index_to_point_top_tb.sv */
// ----------------------------------------------------------------------------
// hilbert_evolvent_index_to_point_top_tb
// Self-checking bench for the evolvent index-to-point block. A directed table
// and random curve positions are sent under several dimension and tightness
// settings; every emitted axis is compared with a behavioral point generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hilbert_evolvent_index_to_point_top_tb;

  localparam int NAXES = 10;
  localparam int NLEV = 20;
  localparam logic [60:0] ONE = 61'd1 << 60;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [61:0] coord;
    logic [3:0]         axis;
    logic               last;
  } axis_res_t;

  typedef struct {
    logic [60:0] pos;
    bit          known;
    logic [61:0] coord0;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [60:0] position_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [61:0] coordinate_o;
  logic [3:0] axis_o;
  logic last_o;

  axis_res_t pending_axes[$];
  logic [3:0] dim_reg;
  logic [4:0] tight_reg;
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int idle_cnt = 0;
  bit timed_out = 1'b0;
  bit quiet = 1'b0;

  hilbert_evolvent_index_to_point_top uut (
    .clk_i, .rst_ni, .start, .busy, .position_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .result_valid_o, .coordinate_o, .axis_o, .last_o
  );

  always #4 clk_i = ~clk_i;

  // sub-cube shape: per-axis direction, twisted direction, exit axis
  task automatic cube_cell(input int digit, input int n, input int cells,
                           output int dirv[NAXES], output int twv[NAXES],
                           output int ex);
    int half, rest, prev, cur, flip;
    ex = n - 1;
    for (int a = 0; a < NAXES; a++) begin
      dirv[a] = -1;
      twv[a] = -1;
    end
    if (digit == cells - 1) begin
      dirv[0] = 1;
      twv[0] = 1;
      twv[n-1] = 1;
    end else if (digit != 0) begin
      half = cells;
      rest = digit;
      prev = -1;
      flip = 0;
      for (int a = 0; a < n; a++) begin
        half = half >> 1;
        if (rest >= half) begin
          if (rest == half && rest != 1) begin ex = a; flip = -1; end
          rest -= half;
          cur = 1;
        end else begin
          cur = -1;
          if (rest == half - 1 && rest != 0) begin ex = a; flip = 1; end
        end
        dirv[a] = -prev * cur;
        twv[a] = dirv[a];
        prev = cur;
      end
      twv[ex] = twv[ex] * flip;
      twv[n-1] = -twv[n-1];
    end
  endtask

  // expected point of one curve position, pushed one entry per axis
  task automatic predict_point(input logic [60:0] pos);
    logic [60:0] x;
    logic [59:0] frac;
    logic signed [63:0] coord[NAXES];
    int orient[NAXES], dirv[NAXES], twv[NAXES];
    int n, levels, cells, rem, entry, digit, ex, t, s;
    bit full;
    axis_res_t r;
    x = (pos > ONE) ? ONE : pos;
    n = (dim_reg == 0) ? 1 : (dim_reg > NAXES) ? NAXES : int'(dim_reg);
    levels = (tight_reg > NLEV) ? NLEV : int'(tight_reg);
    for (int a = 0; a < NAXES; a++) begin
      coord[a] = 0;
      orient[a] = 1;
    end
    if (n == 1) begin
      coord[0] = $signed({3'b0, x}) * 2 - (64'sd1 <<< 60);
    end else begin
      cells = 1 << n;
      rem = 60;
      frac = x[59:0];
      full = (x == ONE);
      entry = 0;
      for (int lev = 0; lev < levels; lev++) begin
        if (full) digit = cells - 1;
        else if (rem >= n) begin
          digit = int'((frac >> (rem - n)) & 60'(cells - 1));
          rem -= n;
        end else if (rem > 0) begin
          digit = int'((frac & ((60'd1 << rem) - 1)) << (n - rem));
          rem = 0;
        end else digit = 0;
        cube_cell(digit, n, cells, dirv, twv, ex);
        t = dirv[0]; dirv[0] = dirv[entry]; dirv[entry] = t;
        t = twv[0]; twv[0] = twv[entry]; twv[entry] = t;
        if (ex == 0) ex = entry;
        else if (ex == entry) ex = 0;
        entry = ex;
        for (int a = 0; a < n; a++) begin
          s = dirv[a] * orient[a];
          orient[a] = -twv[a] * orient[a];
          if (s > 0) coord[a] += (64'sd1 <<< (59 - lev));
          else coord[a] -= (64'sd1 <<< (59 - lev));
        end
      end
    end
    for (int a = 0; a < n; a++) begin
      r.coord = coord[a][61:0];
      r.axis = 4'(a);
      r.last = (a == n - 1);
      pending_axes.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h (request %0d)", what, got, want, n_req);
  endtask

  // result check at every edge
  always @(posedge clk_i) begin
    axis_res_t w;
    if (rst_ni && result_valid_o) begin
      n_res++;
      if (pending_axes.size() == 0)
        report_mismatch("unexpected result", 64'(axis_o), 64'd0);
      else begin
        w = pending_axes.pop_front();
        if (coordinate_o !== w.coord)
          report_mismatch("coordinate", 64'(coordinate_o), 64'(w.coord));
        if (axis_o !== w.axis) report_mismatch("axis", 64'(axis_o), 64'(w.axis));
        if (last_o !== w.last) report_mismatch("last", 64'(last_o), 64'(w.last));
      end
    end
  end

  // watchdog on cycles without any accepted transfer
  always @(posedge clk_i) begin
    if (!rst_ni || result_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCHDOG) begin
      $display("watchdog expired");
      $display("hilbert_evolvent_index_to_point_top_tb failed");
      $finish;
    end
  end

  task automatic idle_gap();
    if (!quiet) while ($urandom_range(99) < 13) @(posedge clk_i);
  endtask

  // start drops after each accept; busy is high then anyway
  task automatic send_request(input logic [60:0] pos);
    idle_gap();
    start <= 1'b1;
    position_i <= pos;
    do @(posedge clk_i); while (busy);
    predict_point(pos);
    n_req++;
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == hevi_pkg::CfgDimension) dim_reg = val[3:0];
    else if (idx == hevi_pkg::CfgTightness) tight_reg = val[4:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_axes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [60:0] rand_pos();
    logic [60:0] p;
    case ($urandom_range(9))
      0: p = ONE;
      1: p = 61'h1FFF_FFFF_FFFF_FFFF;
      2: p = ONE - 1;
      3: p = '0;
      default: p = 61'({$urandom, $urandom}) & (ONE - 1);
    endcase
    return p;
  endfunction

  row_t table_rows[$];

  initial begin
    axis_res_t w;
    logic [7:0] dims[8] = '{8'd2, 8'd1, 8'd10, 8'd3, 8'd0, 8'd15, 8'd5, 8'd4};
    logic [7:0] tights[8] = '{8'd10, 8'd3, 8'd20, 8'd31, 8'd0, 8'd1, 8'd7, 8'd12};
    dim_reg = hevi_pkg::DimensionReset;
    tight_reg = hevi_pkg::TightnessReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings, checked against the point generator
    table_rows.push_back('{61'd0, 1'b0, 62'd0});
    table_rows.push_back('{ONE, 1'b0, 62'd0});
    table_rows.push_back('{ONE - 1, 1'b0, 62'd0});
    table_rows.push_back('{61'h1FFF_FFFF_FFFF_FFFF, 1'b0, 62'd0});
    table_rows.push_back('{ONE >> 1, 1'b0, 62'd0});
    table_rows.push_back('{ONE >> 2, 1'b0, 62'd0});
    table_rows.push_back('{61'h0555_5555_5555_5555, 1'b0, 62'd0});
    table_rows.push_back('{61'h0AAA_AAAA_AAAA_AAAA, 1'b0, 62'd0});
    foreach (table_rows[i]) begin
      send_request(table_rows[i].pos);
    end
    drain();
    // dimension one: plain offset, read straight off
    write_reg(hevi_pkg::CfgDimension, 8'd1);
    foreach (table_rows[i]) begin
      table_rows[i].known = 1'b1;
      table_rows[i].coord0 = ((table_rows[i].pos > ONE) ? 62'(ONE) : 62'(table_rows[i].pos))
                             * 2 - (62'd1 << 60);
      send_request(table_rows[i].pos);
      w = pending_axes[pending_axes.size() - 1];
      if (w.coord !== table_rows[i].coord0)
        report_mismatch("table offset", 64'(w.coord), 64'(table_rows[i].coord0));
    end
    drain();
    for (int d = 3; d <= 10; d++) begin
      write_reg(hevi_pkg::CfgDimension, 8'(d));
      send_request(ONE);
      send_request(61'd0);
      drain();
    end

    // random phases across register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(hevi_pkg::CfgDimension, dims[ph]);
      write_reg(hevi_pkg::CfgTightness, tights[ph]);
      quiet = (ph == 3);
      for (int k = 0; k < 48; k++) send_request(rand_pos());
      drain();
    end
    write_reg(hevi_pkg::CfgDimension, 8'($urandom));
    write_reg(hevi_pkg::CfgTightness, 8'($urandom));
    for (int k = 0; k < 8; k++) send_request(rand_pos());
    drain();

    $display("sent %0d positions, checked %0d axis results over dimensions 0..15",
             n_req, n_res);
    $display("and tightness 0..31 including saturation cases");
    if (errors == 0 && pending_axes.size() == 0) begin
      $display("hilbert_evolvent_index_to_point_top_tb passed");
    end else begin
      $display("hilbert_evolvent_index_to_point_top_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/hevi_pkg.sv
rtl/core/hevi_ctrl.sv
rtl/core/hevi_datapath.sv
rtl/core/hilbert_evolvent_index_to_point_top.sv
test/hilbert_evolvent_index_to_point_top_tb.sv
